// ----- design/eccf_pkg.sv -----
// ----------------------------------------------------------------------------
// eccf_pkg: shared definitions for the circle collision time finder
// Entry format between the front and back parts, operation and axis codes.
// ----------------------------------------------------------------------------
package eccf_pkg;

   localparam int MaxCircles = 1024;
   localparam int QueueDepth = 2;
   localparam int QueuePtrW  = $clog2(QueueDepth);

   localparam logic [16:0] TIME_ONE = 17'h10000;

   // Configuration register indexes.
   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_STEP   = 2'd2;

   // What the back part has to do with an entry.
   localparam logic [1:0] OP_NOP  = 2'd0;
   localparam logic [1:0] OP_WALL = 2'd1;
   localparam logic [1:0] OP_PAIR = 2'd2;

   // Outcome of the front part's look at one wall axis.
   localparam logic [1:0] AX_MISS = 2'd0;
   localparam logic [1:0] AX_ZERO = 2'd1;
   localparam logic [1:0] AX_DIV  = 2'd2;

   typedef struct packed {
      logic [1:0]  cls;
      logic [16:0] num;   // magnitude of the distance to the wall
      logic [16:0] vel;   // magnitude of the scaled velocity
   } axis_type;

   typedef struct packed {
      logic [1:0]         op;
      logic               last;
      logic [9:0]         id_a;
      logic [9:0]         id_b;
      axis_type           ax_x;
      axis_type           ax_y;
      logic signed [16:0] dx;
      logic signed [16:0] dy;
      logic signed [16:0] rvx;
      logic signed [16:0] rvy;
      logic signed [16:0] wx;
      logic signed [16:0] wy;
      logic [12:0]        msum;
   } entry_type;

endpackage

// ----- design/eccf_front.sv -----
// ----------------------------------------------------------------------------
// eccf_front: request intake and classification
// Registers a request, scales velocities, forms differences and wall terms.
// ----------------------------------------------------------------------------
module eccf_front #(
   parameter int MAX_CIRCLES = eccf_pkg::MaxCircles
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_kind,
   input  logic                req_last_of_scan,
   input  logic [9:0]          req_index_a,
   input  logic [9:0]          req_index_b,
   input  logic [31:0]         req_a_position,
   input  logic [31:0]         req_a_velocity,
   input  logic [11:0]         req_a_radius,
   input  logic [31:0]         req_b_position,
   input  logic [31:0]         req_b_velocity,
   input  logic [11:0]         req_b_radius,
   input  logic [10:0]         cfg_width,
   input  logic [10:0]         cfg_height,
   input  logic [16:0]         cfg_step,
   output logic                push_valid,
   input  logic                push_ready,
   output eccf_pkg::entry_type push_data
);

   logic        valid_ff, valid_in;
   logic        kind_ff, last_ff;
   logic [9:0]  ida_ff, idb_ff;
   logic [31:0] apos_ff, avel_ff, bpos_ff, bvel_ff;
   logic [11:0] arad_ff, brad_ff;

   function automatic logic signed [15:0] scale_vel(input logic signed [15:0] v,
                                                    input logic [16:0] s);
      logic signed [33:0] p;
      p = 34'(v) * $signed({1'b0, s});
      if (p < 0) begin
         p = p + 34'sd65535;
      end
      return p[31:16];
   endfunction

   function automatic eccf_pkg::axis_type wall_axis(input logic signed [15:0] pos,
                                                    input logic signed [15:0] vel,
                                                    input logic [11:0] rad,
                                                    input logic [10:0] size);
      logic signed [18:0] pos_e, vel_e, rad_e, pad, fut, num;
      logic [18:0]        num_neg, vel_neg;
      logic               hit;
      eccf_pkg::axis_type ax;
      pos_e   = 19'(pos);
      vel_e   = 19'(vel);
      rad_e   = $signed({7'b0, rad});
      pad     = $signed({4'b0, size, 4'b0}) - rad_e;
      fut     = pos_e + vel_e;
      hit     = (fut > pad) || (fut < rad_e);
      num     = (fut > pad) ? (pad - pos_e) : (rad_e - pos_e);
      num_neg = -num;
      vel_neg = -vel_e;
      ax.num  = num[18] ? num_neg[16:0] : num[16:0];
      ax.vel  = vel_e[18] ? vel_neg[16:0] : vel_e[16:0];
      if (!hit) begin
         ax.cls = eccf_pkg::AX_MISS;
      end else if (vel == 0) begin
         ax.cls = num[18] ? eccf_pkg::AX_ZERO : eccf_pkg::AX_MISS;
      end else if (num != 0 && num[18] != vel[15]) begin
         // Wall time of negative sign counts as an immediate hit.
         ax.cls = eccf_pkg::AX_ZERO;
      end else begin
         ax.cls = eccf_pkg::AX_DIV;
      end
      return ax;
   endfunction

   assign req_ready  = !valid_ff || push_ready;
   assign push_valid = valid_ff;
   assign valid_in   = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         kind_ff <= req_kind;
         last_ff <= req_last_of_scan;
         ida_ff  <= req_index_a;
         idb_ff  <= req_index_b;
         apos_ff <= req_a_position;
         avel_ff <= req_a_velocity;
         arad_ff <= req_a_radius;
         bpos_ff <= req_b_position;
         bvel_ff <= req_b_velocity;
         brad_ff <= req_b_radius;
      end
   end

   logic [16:0]        step_eff;
   logic signed [15:0] sax, say, sbx, sby;
   logic               ok_a, ok_b;

   always_comb begin
      step_eff = (cfg_step > eccf_pkg::TIME_ONE) ? eccf_pkg::TIME_ONE : cfg_step;
      sax = scale_vel($signed(avel_ff[31:16]), step_eff);
      say = scale_vel($signed(avel_ff[15:0]), step_eff);
      sbx = scale_vel($signed(bvel_ff[31:16]), step_eff);
      sby = scale_vel($signed(bvel_ff[15:0]), step_eff);
      ok_a = 32'(ida_ff) < 32'(MAX_CIRCLES);
      ok_b = 32'(idb_ff) < 32'(MAX_CIRCLES);

      if (!ok_a || (kind_ff && !ok_b)) begin
         push_data.op = eccf_pkg::OP_NOP;
      end else if (kind_ff) begin
         push_data.op = eccf_pkg::OP_PAIR;
      end else begin
         push_data.op = eccf_pkg::OP_WALL;
      end
      push_data.last = last_ff;
      push_data.id_a = ida_ff;
      push_data.id_b = idb_ff;
      push_data.ax_x = wall_axis($signed(apos_ff[31:16]), sax, arad_ff, cfg_width);
      push_data.ax_y = wall_axis($signed(apos_ff[15:0]), say, arad_ff, cfg_height);
      push_data.dx   = 17'($signed(apos_ff[31:16])) - 17'($signed(bpos_ff[31:16]));
      push_data.dy   = 17'($signed(apos_ff[15:0])) - 17'($signed(bpos_ff[15:0]));
      push_data.rvx  = 17'($signed(avel_ff[31:16])) - 17'($signed(bvel_ff[31:16]));
      push_data.rvy  = 17'($signed(avel_ff[15:0])) - 17'($signed(bvel_ff[15:0]));
      push_data.wx   = 17'(sax) - 17'(sbx);
      push_data.wy   = 17'(say) - 17'(sby);
      push_data.msum = 13'(arad_ff) + 13'(brad_ff);
   end

endmodule

// ----- design/eccf_queue.sv -----
// ----------------------------------------------------------------------------
// eccf_queue: short entry queue between the front and back parts
// A small circular buffer with a fill count.
// ----------------------------------------------------------------------------
module eccf_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  eccf_pkg::entry_type push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output eccf_pkg::entry_type pop_data
);

   eccf_pkg::entry_type                   mem_ff [eccf_pkg::QueueDepth];
   logic [eccf_pkg::QueuePtrW-1:0]        wr_ff, wr_in, rd_ff, rd_in;
   logic [eccf_pkg::QueuePtrW:0]          cnt_ff, cnt_in;
   logic                                  do_push, do_pop;

   localparam logic [eccf_pkg::QueuePtrW:0] FULL = (eccf_pkg::QueuePtrW + 1)'(eccf_pkg::QueueDepth);
   localparam logic [eccf_pkg::QueuePtrW-1:0] LAST = eccf_pkg::QueuePtrW'(eccf_pkg::QueueDepth - 1);

   assign push_ready = cnt_ff != FULL;
   assign pop_valid  = cnt_ff != '0;
   assign pop_data   = mem_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_in  = do_push ? ((wr_ff == LAST) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop ? ((rd_ff == LAST) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ----- design/eccf_back.sv -----
// ----------------------------------------------------------------------------
// eccf_back: collision time evaluation and earliest hit tracking
// Shared multiply-accumulate, digit-serial square root and divider.
// ----------------------------------------------------------------------------
module eccf_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  eccf_pkg::entry_type pop_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [16:0]         rsp_earliest_time,
   output logic [9:0]          rsp_first_collider,
   output logic [9:0]          rsp_second_collider,
   output logic                rsp_wall_hit,
   output logic                rsp_no_collision
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MAC    = 3'd1;
   localparam logic [2:0] ST_SQRT   = 3'd2;
   localparam logic [2:0] ST_DIVSET = 3'd3;
   localparam logic [2:0] ST_DIV    = 3'd4;
   localparam logic [2:0] ST_WALL   = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   localparam logic [1:0] SH_0  = 2'd0;
   localparam logic [1:0] SH_17 = 2'd1;
   localparam logic [1:0] SH_18 = 2'd2;
   localparam logic [1:0] SH_34 = 2'd3;

   localparam logic [5:0] SQRT_LAST = 6'd33;
   localparam logic [4:0] DIV_LAST  = 5'd16;

   logic [2:0]          state_ff, state_in;
   eccf_pkg::entry_type ent_ff;
   logic [3:0]          step_ff, step_in;
   logic signed [69:0]  acc_ff, acc_next;
   logic [33:0]         a_ff, a_in;
   logic signed [34:0]  b_ff, b_in;
   logic signed [34:0]  c_ff, c_in;
   logic                axis_y_ff, axis_y_in;
   logic [67:0]         rad_ff, rad_in;
   logic [37:0]         rem_ff, rem_in;
   logic [33:0]         root_ff, root_in;
   logic [5:0]          iter_ff, iter_in;
   logic [49:0]         dr_ff, dr_in;
   logic [50:0]         dsh_ff, dsh_in;
   logic [16:0]         quo_ff, quo_in;
   logic [4:0]          dcnt_ff, dcnt_in;
   logic [16:0]         best_time_ff, best_time_in;
   logic [9:0]          best_first_ff, best_first_in;
   logic [9:0]          best_second_ff, best_second_in;
   logic                best_wall_ff, best_wall_in;
   logic                none_ff, none_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [16:0]         rsp_time_ff;
   logic [9:0]          rsp_first_ff, rsp_second_ff;
   logic                rsp_wall_ff, rsp_none_ff;
   logic                rsp_load;

   // Multiply-accumulate operand selection.
   logic signed [17:0] mac_a, mac_b;
   logic [1:0]         mac_sh;
   logic               mac_sub, mac_clr;
   logic signed [35:0] prod;
   logic signed [69:0] term, acc_base;

   function automatic logic signed [17:0] lo17(input logic [33:0] x);
      return $signed({1'b0, x[16:0]});
   endfunction

   function automatic logic signed [17:0] hi17(input logic [33:0] x);
      return $signed({1'b0, x[33:17]});
   endfunction

   logic [34:0] b_neg;
   logic [33:0] bm;

   assign b_neg = -b_ff;
   assign bm    = b_neg[33:0];

   always_comb begin
      mac_a   = '0;
      mac_b   = '0;
      mac_sh  = SH_0;
      mac_sub = 1'b0;
      mac_clr = 1'b0;
      unique case (step_ff)
         4'd0: begin
            mac_a = 18'(ent_ff.rvx); mac_b = 18'(ent_ff.dx); mac_clr = 1'b1;
         end
         4'd1: begin
            mac_a = 18'(ent_ff.rvy); mac_b = 18'(ent_ff.dy);
         end
         4'd2: begin
            mac_a = 18'(ent_ff.wx); mac_b = 18'(ent_ff.wx); mac_clr = 1'b1;
         end
         4'd3: begin
            mac_a = 18'(ent_ff.wy); mac_b = 18'(ent_ff.wy);
         end
         4'd4: begin
            mac_a = 18'(ent_ff.wx); mac_b = 18'(ent_ff.dx); mac_clr = 1'b1;
         end
         4'd5: begin
            mac_a = 18'(ent_ff.wy); mac_b = 18'(ent_ff.dy);
         end
         4'd6: begin
            mac_a = 18'(ent_ff.dx); mac_b = 18'(ent_ff.dx); mac_clr = 1'b1;
         end
         4'd7: begin
            mac_a = 18'(ent_ff.dy); mac_b = 18'(ent_ff.dy);
         end
         4'd8: begin
            mac_a = $signed({5'b0, ent_ff.msum});
            mac_b = $signed({5'b0, ent_ff.msum});
            mac_sub = 1'b1;
         end
         4'd9: begin
            mac_a = lo17(bm); mac_b = lo17(bm); mac_clr = 1'b1;
         end
         4'd10: begin
            // Cross term counted twice through the extra shift.
            mac_a = lo17(bm); mac_b = hi17(bm); mac_sh = SH_18;
         end
         4'd11: begin
            mac_a = hi17(bm); mac_b = hi17(bm); mac_sh = SH_34;
         end
         4'd12: begin
            mac_a = lo17(a_ff); mac_b = lo17(c_ff[33:0]); mac_sub = 1'b1;
         end
         4'd13: begin
            mac_a = lo17(a_ff); mac_b = hi17(c_ff[33:0]); mac_sub = 1'b1; mac_sh = SH_17;
         end
         4'd14: begin
            mac_a = hi17(a_ff); mac_b = lo17(c_ff[33:0]); mac_sub = 1'b1; mac_sh = SH_17;
         end
         default: begin
            mac_a = hi17(a_ff); mac_b = hi17(c_ff[33:0]); mac_sub = 1'b1; mac_sh = SH_34;
         end
      endcase

      prod = mac_a * mac_b;
      term = 70'(prod);
      unique case (mac_sh)
         SH_17:   term = term <<< 17;
         SH_18:   term = term <<< 18;
         SH_34:   term = term <<< 34;
         default: term = term;
      endcase
      acc_base = mac_clr ? '0 : acc_ff;
      acc_next = mac_sub ? (acc_base - term) : (acc_base + term);
   end

   // Square root step: two radicand bits per cycle.
   logic [37:0] rem_sh, sq_trial;
   logic        sq_ge;

   always_comb begin
      rem_sh   = {rem_ff[35:0], rad_ff[67:66]};
      sq_trial = {2'b0, root_ff, 2'b01};
      sq_ge    = rem_sh >= sq_trial;
   end

   // Divider setup and restoring step.
   logic [33:0] div_n;
   logic [34:0] div_d;
   logic        div_ovf;
   logic [50:0] dr_ext;
   logic        div_ge;
   logic [50:0] dr_sub;
   logic [16:0] quo_next;
   eccf_pkg::axis_type ax_cur;

   always_comb begin
      ax_cur = axis_y_ff ? ent_ff.ax_y : ent_ff.ax_x;
      if (ent_ff.op == eccf_pkg::OP_WALL) begin
         div_n = {17'b0, ax_cur.num};
         div_d = {18'b0, ax_cur.vel};
      end else begin
         div_n = c_ff[33:0];
         div_d = {1'b0, bm} + {1'b0, root_ff};
      end
      div_ovf  = {2'b0, div_n} >= {div_d, 1'b0};
      dr_ext   = {1'b0, dr_ff};
      div_ge   = dr_ext >= dsh_ff;
      dr_sub   = dr_ext - dsh_ff;
      quo_next = {quo_ff[15:0], div_ge};
   end

   logic        rec_en;
   logic [16:0] rec_time;
   logic [9:0]  rec_second;
   logic        rec_wall;
   logic        dnz;

   assign dnz       = (ent_ff.dx != 0) || (ent_ff.dy != 0);
   assign pop_ready = state_ff == ST_IDLE;
   assign rsp_load  = (state_ff == ST_FINISH) && ent_ff.last && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      c_in      = c_ff;
      axis_y_in = axis_y_ff;
      rad_in    = rad_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      iter_in   = iter_ff;
      dr_in     = dr_ff;
      dsh_in    = dsh_ff;
      quo_in    = quo_ff;
      dcnt_in   = dcnt_ff;
      rec_en    = 1'b0;
      rec_time  = '0;
      rec_second = ent_ff.id_b;
      rec_wall  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               axis_y_in = 1'b0;
               step_in   = '0;
               unique case (pop_data.op)
                  eccf_pkg::OP_WALL: state_in = ST_WALL;
                  eccf_pkg::OP_PAIR: state_in = ST_MAC;
                  default:           state_in = ST_FINISH;
               endcase
            end
         end
         ST_MAC: begin
            step_in = step_ff + 1'b1;
            unique case (step_ff)
               4'd1: begin
                  // Pairs that move apart are skipped.
                  if (dnz && !acc_next[69]) begin
                     state_in = ST_FINISH;
                  end
               end
               4'd3: begin
                  a_in = acc_next[33:0];
                  if (acc_next[33:0] == 0) begin
                     state_in = ST_FINISH;
                  end
               end
               4'd5: b_in = acc_next[34:0];
               4'd8: begin
                  c_in = acc_next[34:0];
                  if (acc_next[69]) begin
                     // Already overlapping.
                     rec_en   = 1'b1;
                     state_in = ST_FINISH;
                  end else if (!b_ff[34]) begin
                     rec_en   = (acc_next[34:0] == 0) && (b_ff == 0) && (best_time_ff != 0);
                     state_in = ST_FINISH;
                  end else if (acc_next[34:0] == 0) begin
                     rec_en   = best_time_ff != 0;
                     state_in = ST_FINISH;
                  end
               end
               4'd15: begin
                  if (acc_next[69]) begin
                     // Negative discriminant.
                     state_in = ST_FINISH;
                  end else begin
                     rad_in   = acc_next[67:0];
                     rem_in   = '0;
                     root_in  = '0;
                     iter_in  = '0;
                     state_in = ST_SQRT;
                  end
               end
               default: ;
            endcase
         end
         ST_SQRT: begin
            rem_in  = sq_ge ? (rem_sh - sq_trial) : rem_sh;
            root_in = {root_ff[32:0], sq_ge};
            rad_in  = {rad_ff[65:0], 2'b00};
            iter_in = iter_ff + 1'b1;
            if (iter_ff == SQRT_LAST) begin
               state_in = ST_DIVSET;
            end
         end
         ST_WALL: begin
            rec_second = {9'b0, axis_y_ff};
            rec_wall   = 1'b1;
            unique case (ax_cur.cls)
               eccf_pkg::AX_ZERO: begin
                  rec_en   = 1'b1;
                  state_in = ST_FINISH;
               end
               eccf_pkg::AX_DIV: state_in = ST_DIVSET;
               default: begin
                  if (axis_y_ff) begin
                     state_in = ST_FINISH;
                  end else begin
                     axis_y_in = 1'b1;
                  end
               end
            endcase
         end
         ST_DIVSET: begin
            if (div_ovf) begin
               // Quotient is at least two substeps: never the earliest.
               if (ent_ff.op == eccf_pkg::OP_WALL && !axis_y_ff) begin
                  axis_y_in = 1'b1;
                  state_in  = ST_WALL;
               end else begin
                  state_in = ST_FINISH;
               end
            end else begin
               dr_in    = {div_n, 16'b0};
               dsh_in   = {div_d, 16'b0};
               quo_in   = '0;
               dcnt_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            dr_in   = div_ge ? dr_sub[49:0] : dr_ff;
            dsh_in  = {1'b0, dsh_ff[50:1]};
            quo_in  = quo_next;
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DIV_LAST) begin
               rec_time = quo_next;
               if (ent_ff.op == eccf_pkg::OP_WALL) begin
                  rec_second = {9'b0, axis_y_ff};
                  rec_wall   = 1'b1;
               end
               if (quo_next < best_time_ff) begin
                  rec_en   = 1'b1;
                  state_in = ST_FINISH;
               end else if (ent_ff.op == eccf_pkg::OP_WALL && !axis_y_ff) begin
                  axis_y_in = 1'b1;
                  state_in  = ST_WALL;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (!ent_ff.last || rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      best_time_in   = best_time_ff;
      best_first_in  = best_first_ff;
      best_second_in = best_second_ff;
      best_wall_in   = best_wall_ff;
      none_in        = none_ff;
      if (rsp_load) begin
         best_time_in   = eccf_pkg::TIME_ONE;
         best_first_in  = '0;
         best_second_in = '0;
         best_wall_in   = 1'b0;
         none_in        = 1'b1;
      end else if (rec_en) begin
         best_time_in   = rec_time;
         best_first_in  = ent_ff.id_a;
         best_second_in = rec_second;
         best_wall_in   = rec_wall;
         none_in        = 1'b0;
      end
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         best_time_ff   <= eccf_pkg::TIME_ONE;
         best_first_ff  <= '0;
         best_second_ff <= '0;
         best_wall_ff   <= 1'b0;
         none_ff        <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         best_time_ff   <= best_time_in;
         best_first_ff  <= best_first_in;
         best_second_ff <= best_second_in;
         best_wall_ff   <= best_wall_in;
         none_ff        <= none_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_valid && pop_ready) begin
         ent_ff <= pop_data;
      end
      if (state_ff == ST_MAC) begin
         acc_ff <= acc_next;
      end
      step_ff   <= step_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      c_ff      <= c_in;
      axis_y_ff <= axis_y_in;
      rad_ff    <= rad_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      iter_ff   <= iter_in;
      dr_ff     <= dr_in;
      dsh_ff    <= dsh_in;
      quo_ff    <= quo_in;
      dcnt_ff   <= dcnt_in;
      if (rsp_load) begin
         rsp_time_ff   <= best_time_ff;
         rsp_first_ff  <= best_first_ff;
         rsp_second_ff <= best_second_ff;
         rsp_wall_ff   <= best_wall_ff;
         rsp_none_ff   <= none_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_earliest_time   = rsp_time_ff;
   assign rsp_first_collider  = rsp_first_ff;
   assign rsp_second_collider = rsp_second_ff;
   assign rsp_wall_hit        = rsp_wall_ff;
   assign rsp_no_collision    = rsp_none_ff;

endmodule

// ----- design/earliest_circle_collision_finder.sv -----
// ----------------------------------------------------------------------------
// earliest_circle_collision_finder: swept circle collision time search
// Keeps the earliest wall or pair collision of a scan and reports it.
// ----------------------------------------------------------------------------
// Path: the front register and the queue, then in the back part up to take,
// multiply-accumulate, square root, divider and finish for a pair request,
// take, wall, divider and finish for a wall request and take and finish for
// an identifier out of range; the response register loads as finish ends.
// Throughput: one request at a time in the back part, set by the shared loop.
// Reset (synchronous): scan cleared to t = 1, registers 640, 480 and 65536.
module earliest_circle_collision_finder #(
   parameter int MAX_CIRCLES = eccf_pkg::MaxCircles
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic        req_last_of_scan,
   input  logic [9:0]  req_index_a,
   input  logic [9:0]  req_index_b,
   input  logic [31:0] req_a_position,
   input  logic [31:0] req_a_velocity,
   input  logic [11:0] req_a_radius,
   input  logic [31:0] req_b_position,
   input  logic [31:0] req_b_velocity,
   input  logic [11:0] req_b_radius,
   // Response channel.
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [16:0] rsp_earliest_time,
   output logic [9:0]  rsp_first_collider,
   output logic [9:0]  rsp_second_collider,
   output logic        rsp_wall_hit,
   output logic        rsp_no_collision,
   // Configuration write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_data
);

   // Configuration registers, read directly by the front part. The user must
   // change them only while the block is idle; the block does not enforce it.
   logic [10:0] width_ff, height_ff;
   logic [16:0] step_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd640;
         height_ff <= 11'd480;
         step_ff   <= eccf_pkg::TIME_ONE;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            eccf_pkg::CSR_WIDTH:  width_ff  <= csr_data[10:0];
            eccf_pkg::CSR_HEIGHT: height_ff <= csr_data[10:0];
            eccf_pkg::CSR_STEP:   step_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // The front part registers each request, scales velocities and classifies
   // the test; the queue lets it keep taking requests while the back part
   // is busy with a long pair evaluation.
   logic                push_valid, push_ready, pop_valid, pop_ready;
   eccf_pkg::entry_type push_data, pop_data;

   eccf_front #(
      .MAX_CIRCLES(MAX_CIRCLES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_last_of_scan (req_last_of_scan),
      .req_index_a      (req_index_a),
      .req_index_b      (req_index_b),
      .req_a_position   (req_a_position),
      .req_a_velocity   (req_a_velocity),
      .req_a_radius     (req_a_radius),
      .req_b_position   (req_b_position),
      .req_b_velocity   (req_b_velocity),
      .req_b_radius     (req_b_radius),
      .cfg_width        (width_ff),
      .cfg_height       (height_ff),
      .cfg_step         (step_ff),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_data        (push_data)
   );

   eccf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // The back part holds the running earliest hit and the response register. A
   // pending response holds a scan's last request in the finish step until it is
   // taken; the queue and the front part keep accepting until they fill up.
   eccf_back u_back (
      .clock               (clock),
      .reset               (reset),
      .pop_valid           (pop_valid),
      .pop_ready           (pop_ready),
      .pop_data            (pop_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_earliest_time   (rsp_earliest_time),
      .rsp_first_collider  (rsp_first_collider),
      .rsp_second_collider (rsp_second_collider),
      .rsp_wall_hit        (rsp_wall_hit),
      .rsp_no_collision    (rsp_no_collision)
   );

endmodule

// ----- test/tb_earliest_circle_collision_finder.sv -----
// ----------------------------------------------------------------------------
// tb_earliest_circle_collision_finder: self-checking bench for the finder
// A short table of directed requests is followed by phases of random wall and
// pair requests under several register settings and idling patterns. Every
// response is compared field by field with a typed-in or behavioral prediction.
// ----------------------------------------------------------------------------
module tb_earliest_circle_collision_finder;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic        kind;
      logic        last;
      logic [9:0]  ia;
      logic [9:0]  ib;
      logic [31:0] apos;
      logic [31:0] avel;
      logic [11:0] arad;
      logic [31:0] bpos;
      logic [31:0] bvel;
      logic [11:0] brad;
   } req_type;

   typedef struct {
      logic [16:0] t;
      logic [9:0]  first;
      logic [9:0]  second;
      logic        wall;
      logic        none;
   } rsp_type;

   // Register index with no register behind it.
   localparam logic [1:0] CSR_SPARE = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_kind = 1'b0, req_last_of_scan = 1'b0;
   logic [9:0] req_index_a = '0, req_index_b = '0;
   logic [31:0] req_a_position = '0, req_a_velocity = '0;
   logic [31:0] req_b_position = '0, req_b_velocity = '0;
   logic [11:0] req_a_radius = '0, req_b_radius = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [16:0] rsp_earliest_time;
   logic [9:0] rsp_first_collider, rsp_second_collider;
   logic rsp_wall_hit, rsp_no_collision;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = eccf_pkg::CSR_WIDTH;
   logic [16:0] csr_data = '0;

   earliest_circle_collision_finder dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow registers and the scan state as the block should hold them.
   logic [10:0] cfg_width = 11'd640, cfg_height = 11'd480;
   logic [16:0] cfg_step = eccf_pkg::TIME_ONE;
   logic [16:0] scan_time = eccf_pkg::TIME_ONE;
   logic [9:0]  scan_first = '0, scan_second = '0;
   logic        scan_wall = 1'b0, scan_none = 1'b1;

   rsp_type pending_q[$];
   int errors = 0, n_rsp = 0, n_pair = 0, n_wall = 0;
   int idle_pct = 0, stall_pct = 0;

   task automatic report(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
   endtask

   function automatic longint sx16(input logic [15:0] v);
      return longint'($signed(v));
   endfunction

   // Velocity scaled by the substep fraction, truncated toward zero.
   function automatic longint scale_v(input longint v);
      longint s;
      s = (cfg_step > eccf_pkg::TIME_ONE) ? 65536 : longint'(cfg_step);
      return (v * s) / 65536;
   endfunction

   // Time to record for one wall axis, or -1 when the axis gives nothing.
   function automatic longint axis_time(input longint pos, input longint vel,
                                        input longint rad, input longint pad);
      longint fut, num, q;
      fut = pos + vel;
      if (fut > pad) num = pad - pos;
      else if (fut < rad) num = rad - pos;
      else return -1;
      if (vel == 0) return (num < 0) ? 0 : -1;
      // A wall time of negative sign means the circle is already past it.
      if (num != 0 && ((num < 0) != (vel < 0))) return 0;
      q = (num * 65536) / vel;
      return (q < longint'(scan_time)) ? q : -1;
   endfunction

   function automatic logic [63:0] root_floor(input logic [127:0] d);
      logic [63:0] r, c;
      r = '0;
      for (int i = 35; i >= 0; i--) begin
         c = r | (64'd1 << i);
         if ({64'd0, c} * {64'd0, c} <= d) r = c;
      end
      return r;
   endfunction

   task automatic take_hit(input logic [16:0] t, input logic [9:0] f,
                           input logic [9:0] s, input logic w);
      scan_time = t;
      scan_first = f;
      scan_second = s;
      scan_wall = w;
      scan_none = 1'b0;
   endtask

   task automatic wall_check(input req_type r);
      longint rad, t;
      rad = longint'(r.arad);
      t = axis_time(sx16(r.apos[31:16]), scale_v(sx16(r.avel[31:16])), rad,
                    (longint'(cfg_width) << 4) - rad);
      if (t >= 0) begin
         take_hit(t[16:0], r.ia, 10'd0, 1'b1);
         return;
      end
      t = axis_time(sx16(r.apos[15:0]), scale_v(sx16(r.avel[15:0])), rad,
                    (longint'(cfg_height) << 4) - rad);
      if (t >= 0) take_hit(t[16:0], r.ia, 10'd1, 1'b1);
   endtask

   task automatic pair_check(input req_type r);
      longint dx, dy, rvx, rvy, wx, wy, m, a, b, c;
      logic [63:0] bm, s, t;
      logic [127:0] p, q;
      dx = sx16(r.apos[31:16]) - sx16(r.bpos[31:16]);
      dy = sx16(r.apos[15:0]) - sx16(r.bpos[15:0]);
      rvx = sx16(r.avel[31:16]) - sx16(r.bvel[31:16]);
      rvy = sx16(r.avel[15:0]) - sx16(r.bvel[15:0]);
      m = longint'(r.arad) + longint'(r.brad);
      // Moving apart is judged on raw velocities; coincident centers never are.
      if ((dx != 0 || dy != 0) && rvx * dx + rvy * dy >= 0) return;
      wx = scale_v(sx16(r.avel[31:16])) - scale_v(sx16(r.bvel[31:16]));
      wy = scale_v(sx16(r.avel[15:0])) - scale_v(sx16(r.bvel[15:0]));
      a = wx * wx + wy * wy;
      if (a == 0) return;
      b = wx * dx + wy * dy;
      c = dx * dx + dy * dy - m * m;
      if (c < 0) begin
         take_hit(17'd0, r.ia, r.ib, 1'b0);
         return;
      end
      if (b >= 0) begin
         if (c == 0 && b == 0 && scan_time > 0) take_hit(17'd0, r.ia, r.ib, 1'b0);
         return;
      end
      if (c == 0) begin
         if (scan_time > 0) take_hit(17'd0, r.ia, r.ib, 1'b0);
         return;
      end
      bm = 64'(-b);
      p = {64'd0, bm} * {64'd0, bm};
      q = {64'd0, 64'(a)} * {64'd0, 64'(c)};
      if (p < q) return;
      s = root_floor(p - q);
      t = (64'(c) * 64'd65536) / (bm + s);
      if (t < 64'(scan_time)) take_hit(t[16:0], r.ia, r.ib, 1'b0);
   endtask

   // Runs one accepted request through the prediction; the scan result is
   // returned through got when the request closes the scan.
   task automatic predict_scan(input req_type r, output bit emits, output rsp_type got);
      if (r.kind) begin
         pair_check(r);
         n_pair++;
      end else begin
         wall_check(r);
         n_wall++;
      end
      emits = r.last;
      got = '{scan_time, scan_first, scan_second, scan_wall, scan_none};
      if (r.last) begin
         scan_time = eccf_pkg::TIME_ONE;
         scan_first = '0;
         scan_second = '0;
         scan_wall = 1'b0;
         scan_none = 1'b1;
      end
   endtask

   // Drives one request and waits for its handshake; the sender may idle first.
   task automatic send_req(input req_type r, input bit typed, input rsp_type typed_rsp);
      bit emits;
      rsp_type pred, want;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= r.kind;
      req_last_of_scan <= r.last;
      req_index_a <= r.ia;
      req_index_b <= r.ib;
      req_a_position <= r.apos;
      req_a_velocity <= r.avel;
      req_a_radius <= r.arad;
      req_b_position <= r.bpos;
      req_b_velocity <= r.bvel;
      req_b_radius <= r.brad;
      do @(posedge clock); while (!req_ready);
      predict_scan(r, emits, pred);
      if (emits) begin
         want = typed ? typed_rsp : pred;
         pending_q = {pending_q, want};
      end
   endtask

   // Leaves csr_valid high; the caller drops it once the writes are done.
   task automatic csr_write(input logic [1:0] idx, input logic [16:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == eccf_pkg::CSR_WIDTH) cfg_width = data[10:0];
      else if (idx == eccf_pkg::CSR_HEIGHT) cfg_height = data[10:0];
      else if (idx == eccf_pkg::CSR_STEP) cfg_step = data;
   endtask

   // Holds the sender until every response is back, then waits long enough
   // for requests that close no scan to leave the front, queue and back part.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_q.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   function automatic logic [31:0] xy(input int x, input int y);
      logic [15:0] hx, hy;
      hx = x[15:0];
      hy = y[15:0];
      return {hx, hy};
   endfunction

   function automatic int srange(input int lim);
      return int'($urandom_range(2 * lim)) - lim;
   endfunction

   // Most random requests are plausible scenes: circles in or near the walls and
   // pairs that head roughly toward each other. The rest are raw bit noise.
   function automatic req_type rand_req();
      req_type r;
      int sel, bx, by, ox, oy, vbx, vby, k, px, py;
      sel = int'($urandom_range(9));
      r.last = ($urandom_range(3) == 0);
      r.ia = 10'($urandom_range(1023));
      r.ib = 10'($urandom_range(1023));
      r.apos = $urandom;
      r.avel = $urandom;
      r.bpos = $urandom;
      r.bvel = $urandom;
      r.arad = 12'($urandom_range(4095));
      r.brad = 12'($urandom_range(4095));
      r.kind = 1'($urandom_range(1));
      if (sel < 4) begin
         r.kind = 1'b1;
         bx = int'($urandom_range(10240));
         by = int'($urandom_range(7680));
         ox = srange(800);
         oy = srange(800);
         vbx = srange(256);
         vby = srange(256);
         k = int'($urandom_range(1, 8));
         r.bpos = xy(bx, by);
         r.apos = xy(bx + ox, by + oy);
         r.bvel = xy(vbx, vby);
         r.avel = xy(vbx - ox / k + srange(16), vby - oy / k + srange(16));
         r.arad = 12'($urandom_range(400));
         r.brad = 12'($urandom_range(400));
      end else if (sel < 7) begin
         r.kind = 1'b0;
         px = int'($urandom_range(int'(cfg_width) * 16 + 400)) - 200;
         py = int'($urandom_range(int'(cfg_height) * 16 + 400)) - 200;
         r.apos = xy(px, py);
         r.avel = xy(srange(1024), srange(1024));
         r.arad = 12'($urandom_range(400));
      end
      return r;
   endfunction

   // Directed table: requests with a response typed in where it is obvious.
   req_type dir_req[$];
   bit      dir_typed[$];
   rsp_type dir_rsp[$];

   task automatic add_row(input req_type r, input bit typed, input rsp_type e);
      dir_req = {dir_req, r};
      dir_typed = {dir_typed, typed};
      dir_rsp = {dir_rsp, e};
   endtask

   // Response checker; the receiver stalls at random.
   always @(posedge clock) begin : rsp_check
      rsp_type e;
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         n_rsp++;
         if (pending_q.size() == 0) begin
            report("response with no request pending");
         end else begin
            e = pending_q.pop_front();
            if (rsp_earliest_time !== e.t)
               report($sformatf("earliest_time %0d, wanted %0d", rsp_earliest_time, e.t));
            if (rsp_first_collider !== e.first)
               report($sformatf("first_collider %0d, wanted %0d",
                                rsp_first_collider, e.first));
            if (rsp_second_collider !== e.second)
               report($sformatf("second_collider %0d, wanted %0d",
                                rsp_second_collider, e.second));
            if (rsp_wall_hit !== e.wall)
               report($sformatf("wall_hit %0b, wanted %0b", rsp_wall_hit, e.wall));
            if (rsp_no_collision !== e.none)
               report($sformatf("no_collision %0b, wanted %0b", rsp_no_collision, e.none));
         end
      end
   end

   initial begin
      #5ms;
      $display("tb: failure");
      $finish;
   end

   localparam rsp_type NO_HIT = '{eccf_pkg::TIME_ONE, 10'd0, 10'd0, 1'b0, 1'b1};

   initial begin : stimulus
      int cfg_set[8][3];
      req_type r;
      rsp_type e;
      cfg_set = '{'{640, 480, 65536}, '{1, 1, 1}, '{2047, 2047, 65536},
                  '{2047, 1, 131071}, '{100, 2047, 32768}, '{1, 2047, 200},
                  '{800, 600, 49152}, '{2047, 2047, 1}};

      // Rows: {kind, last, ia, ib, apos, avel, arad, bpos, bvel, brad}.
      // Circle resting mid-scene right after reset: nothing to report.
      add_row('{0, 1, 1, 0, xy(5120, 3840), 0, 160, 0, 0, 0}, 1, NO_HIT);
      // Zero velocity past the far wall hits at once on the x axis.
      add_row('{0, 1, 5, 9, xy(11200, 100), 0, 16, 0, 0, 0}, 1,
              '{17'd0, 10'd5, 10'd0, 1'b1, 1'b0});
      // Zero velocity below the near wall on y is a miss.
      add_row('{0, 1, 6, 0, xy(5120, 0), 0, 160, 0, 0, 0}, 1, NO_HIT);
      // Coincident overlapping circles register t = 0 for the pair.
      add_row('{1, 1, 3, 7, xy(1600, 1600), xy(16, 0), 80, xy(1600, 1600), 0, 80}, 1,
              '{17'd0, 10'd3, 10'd7, 1'b0, 1'b0});
      // Pair moving apart, then no relative motion, then a near miss.
      add_row('{1, 0, 10, 11, xy(1600, 1600), xy(-16, 0), 16, xy(2000, 1600), 0, 16}, 0,
              NO_HIT);
      add_row('{1, 0, 12, 13, xy(1600, 1600), xy(32, 8), 16, xy(2000, 1600), xy(32, 8), 16},
              0, NO_HIT);
      add_row('{1, 1, 14, 15, xy(0, 0), xy(64, 0), 16, xy(1600, 800), 0, 16}, 1, NO_HIT);
      // Touching and approaching, then overlap again with best time at zero.
      add_row('{1, 0, 20, 21, xy(1600, 1600), xy(16, 0), 160, xy(1920, 1600), 0, 160}, 0,
              NO_HIT);
      add_row('{1, 1, 22, 23, xy(100, 100), xy(1, 1), 50, xy(120, 100), 0, 50}, 0, NO_HIT);
      // Ordinary earliest root among several pairs and walls.
      add_row('{1, 0, 30, 31, xy(1600, 1600), xy(400, 0), 80, xy(3200, 1600), 0, 80}, 0,
              NO_HIT);
      add_row('{0, 0, 32, 0, xy(9900, 3000), xy(800, 0), 80, 0, 0, 0}, 0, NO_HIT);
      add_row('{0, 1, 33, 0, xy(4000, 7500), xy(0, 600), 80, 0, 0, 0}, 0, NO_HIT);
      // Wall times of negative sign, past either wall, moving outward.
      add_row('{0, 1, 40, 0, xy(10300, 3000), xy(50, 0), 80, 0, 0, 0}, 0, NO_HIT);
      add_row('{0, 1, 41, 0, xy(4000, -100), xy(0, -50), 80, 0, 0, 0}, 0, NO_HIT);
      // Field extremes, all ones and all zeros.
      add_row('{1, 1, 1023, 1023, '1, '1, 12'hFFF, '1, '1, 12'hFFF}, 0, NO_HIT);
      add_row('{0, 1, 1023, 1023, '1, '1, 12'hFFF, '1, '1, 12'hFFF}, 0, NO_HIT);
      add_row('{1, 1, 0, 0, 0, 0, 0, 0, 0, 0}, 0, NO_HIT);
      add_row('{0, 1, 0, 0, 0, 0, 0, 0, 0, 0}, 0, NO_HIT);
      add_row('{1, 1, 511, 512, xy(32767, -32768), xy(-32768, 32767), 12'hFFF,
                xy(-32768, 32767), xy(32767, -32768), 12'hFFF}, 0, NO_HIT);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_req[i]) send_req(dir_req[i], dir_typed[i], dir_rsp[i]);
      drain();

      // Random phases, each with its own register setting and idling pattern.
      for (int ph = 0; ph < 8; ph++) begin
         csr_write(eccf_pkg::CSR_WIDTH, 17'(cfg_set[ph][0]));
         csr_write(eccf_pkg::CSR_HEIGHT, 17'(cfg_set[ph][1]));
         csr_write(eccf_pkg::CSR_STEP, 17'(cfg_set[ph][2]));
         // The unused index must leave every register alone.
         if (ph == 2) csr_write(CSR_SPARE, 17'h1FFFF);
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 75; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 75; end
            default: begin idle_pct = 8; stall_pct = 8; end
         endcase
         csr_valid <= 1'b0;
         @(posedge clock);
         for (int n = 0; n < 88; n++) begin
            r = rand_req();
            send_req(r, 0, e);
            // Midway through one phase the sender waits for every response.
            if (ph == 1 && n == 40) drain();
         end
         drain();
      end

      $display("covered %0d pair and %0d wall requests, %0d scan responses,",
               n_pair, n_wall, n_rsp);
      $display("over 8 register settings and four idling patterns");
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/eccf_pkg.sv
design/eccf_front.sv
design/eccf_queue.sv
design/eccf_back.sv
design/earliest_circle_collision_finder.sv
test/tb_earliest_circle_collision_finder.sv
